### rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Transaction structs, micro-word layout, step codes and default sizes.
// No dependencies.
package ffba_pkg;

	localparam int POOL_UNITS_DEF   = 4096;
	localparam int HEADER_UNITS_DEF = 1;

	localparam int REQ_W   = 13;
	localparam int FADDR_W = 12;
	localparam int BADDR_W = 12;

	typedef struct packed {
		logic               action;
		logic [REQ_W-1:0]   request_size;
		logic [FADDR_W-1:0] free_address;
	} cmd_t;

	typedef struct packed {
		logic               granted;
		logic [BADDR_W-1:0] block_address;
	} res_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		RES_KEEP,
		RES_GRANT,
		RES_ZERO
	} res_sel_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_CMD,
		C_FREE,
		C_END,
		C_BAD,
		C_FIT,
		C_OUT_BUSY
	} cond_t;

	// datapath strobes of one micro-word
	typedef struct packed {
		logic     ready;
		logic     rd;
		logic     cap;
		logic     adv;
		logic     wr_head;
		logic     wr_split;
		logic     wr_free;
		logic     set_hint;
		res_sel_t res_set;
		logic     emit;
	} dp_ctrl_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic cmd_valid;
		logic is_free;
		logic pos_end;
		logic bad;
		logic fit;
		logic out_busy;
	} dp_status_t;

	localparam int STEP_W = 4;

	typedef struct packed {
		dp_ctrl_t          dp;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
	localparam logic [STEP_W-1:0] ST_LOOK  = 4'd2;
	localparam logic [STEP_W-1:0] ST_CHECK = 4'd3;
	localparam logic [STEP_W-1:0] ST_TEST  = 4'd4;
	localparam logic [STEP_W-1:0] ST_ADV   = 4'd5;
	localparam logic [STEP_W-1:0] ST_GRANT = 4'd6;
	localparam logic [STEP_W-1:0] ST_SPLIT = 4'd7;
	localparam logic [STEP_W-1:0] ST_FAIL  = 4'd8;
	localparam logic [STEP_W-1:0] ST_FREE  = 4'd9;
	localparam logic [STEP_W-1:0] ST_EMITW = 4'd10;
	localparam logic [STEP_W-1:0] ST_EMIT  = 4'd11;

endpackage

### rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/ffba_useq.sv
// Microcode sequencer: control ROM, step counter and conditional jump.
// Depends on ffba_pkg.
module ffba_useq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ffba_pkg::dp_status_t  status,
	output ffba_pkg::dp_ctrl_t    ctrl
);

	function automatic ffba_pkg::uword_t ucode(input logic [ffba_pkg::STEP_W-1:0] step);
		ffba_pkg::uword_t w;
		w        = '0;
		w.cond   = ffba_pkg::C_NEVER;
		w.target = ffba_pkg::ST_IDLE;
		w.dp.res_set = ffba_pkg::RES_KEEP;
		unique case (step)
			ffba_pkg::ST_IDLE: begin
				w.dp.ready = 1'b1;
				w.cond     = ffba_pkg::C_NO_CMD;
				w.target   = ffba_pkg::ST_IDLE;
			end
			ffba_pkg::ST_DISP: begin
				w.cond   = ffba_pkg::C_FREE;
				w.target = ffba_pkg::ST_FREE;
			end
			ffba_pkg::ST_LOOK: begin
				w.dp.rd  = 1'b1;
				w.cond   = ffba_pkg::C_END;
				w.target = ffba_pkg::ST_FAIL;
			end
			ffba_pkg::ST_CHECK: begin
				w.dp.cap = 1'b1;
				w.cond   = ffba_pkg::C_BAD;
				w.target = ffba_pkg::ST_FAIL;
			end
			ffba_pkg::ST_TEST: begin
				w.cond   = ffba_pkg::C_FIT;
				w.target = ffba_pkg::ST_GRANT;
			end
			ffba_pkg::ST_ADV: begin
				w.dp.adv = 1'b1;
				w.cond   = ffba_pkg::C_ALWAYS;
				w.target = ffba_pkg::ST_LOOK;
			end
			ffba_pkg::ST_GRANT: begin
				w.dp.wr_head = 1'b1;
			end
			ffba_pkg::ST_SPLIT: begin
				w.dp.wr_split = 1'b1;
				w.dp.set_hint = 1'b1;
				w.dp.res_set  = ffba_pkg::RES_GRANT;
				w.cond        = ffba_pkg::C_ALWAYS;
				w.target      = ffba_pkg::ST_EMITW;
			end
			ffba_pkg::ST_FAIL: begin
				w.dp.res_set = ffba_pkg::RES_ZERO;
				w.cond       = ffba_pkg::C_ALWAYS;
				w.target     = ffba_pkg::ST_EMITW;
			end
			ffba_pkg::ST_FREE: begin
				w.dp.wr_free = 1'b1;
				w.dp.res_set = ffba_pkg::RES_ZERO;
			end
			ffba_pkg::ST_EMITW: begin
				w.cond   = ffba_pkg::C_OUT_BUSY;
				w.target = ffba_pkg::ST_EMITW;
			end
			ffba_pkg::ST_EMIT: begin
				w.dp.emit = 1'b1;
				w.cond    = ffba_pkg::C_ALWAYS;
				w.target  = ffba_pkg::ST_IDLE;
			end
			default: begin
				w.cond   = ffba_pkg::C_ALWAYS;
				w.target = ffba_pkg::ST_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [ffba_pkg::STEP_W-1:0] upc_q;
	logic [ffba_pkg::STEP_W-1:0] upc_next;
	ffba_pkg::uword_t            uw;
	logic                        take;

	assign uw   = ucode(upc_q);
	assign ctrl = uw.dp;

	always_comb begin
		unique case (uw.cond)
			ffba_pkg::C_NEVER:    take = 1'b0;
			ffba_pkg::C_ALWAYS:   take = 1'b1;
			ffba_pkg::C_NO_CMD:   take = !status.cmd_valid;
			ffba_pkg::C_FREE:     take = status.is_free;
			ffba_pkg::C_END:      take = status.pos_end;
			ffba_pkg::C_BAD:      take = status.bad;
			ffba_pkg::C_FIT:      take = status.fit;
			ffba_pkg::C_OUT_BUSY: take = status.out_busy;
			default:              take = 1'b1;
		endcase
	end

	assign upc_next = take ? uw.target : upc_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ffba_pkg::ST_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

### rtl/ffba_datapath.sv
// Allocator datapath: command and walk registers, hint, header RAMs, result register.
// Depends on ffba_pkg and ffba_ram; driven by the strobes of ffba_useq.
module ffba_datapath #(
	parameter int POOL_UNITS   = ffba_pkg::POOL_UNITS_DEF,
	parameter int HEADER_UNITS = ffba_pkg::HEADER_UNITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffba_pkg::dp_ctrl_t   ctrl,
	output ffba_pkg::dp_status_t status,
	input  logic                 cmd_valid,
	input  ffba_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ffba_pkg::res_t       res
);

	localparam int ADDR_W = $clog2(POOL_UNITS);
	localparam int CNT_W  = $clog2(POOL_UNITS + 1);
	localparam int NEED_W = ((CNT_W > ffba_pkg::REQ_W) ? CNT_W : ffba_pkg::REQ_W) + 1;
	localparam int FA_W   = (CNT_W > ffba_pkg::FADDR_W) ? CNT_W : ffba_pkg::FADDR_W;
	localparam int OA_W   = (CNT_W + 1 > ffba_pkg::BADDR_W) ? CNT_W + 1 : ffba_pkg::BADDR_W;

	ffba_pkg::cmd_t              item_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            hint_q;
	logic [CNT_W-1:0]            sz_q;
	logic                        hfree_q;
	logic                        free0_wr_q;
	logic                        size0_wr_q;
	logic                        res_grant_q;
	logic [ffba_pkg::BADDR_W-1:0] res_addr_q;
	logic                        res_valid_q;
	ffba_pkg::res_t              res_q;

	logic                        cmd_fire;
	logic [NEED_W-1:0]           need;
	logic                        rd_free_ram;
	logic [CNT_W-1:0]            rd_size_ram;
	logic                        rd_is0;
	logic                        rd_free;
	logic [CNT_W-1:0]            rd_size;
	logic [CNT_W-1:0]            room;
	logic [CNT_W-1:0]            rest;
	logic                        split_ok;
	logic [CNT_W-1:0]            taken;
	logic [CNT_W-1:0]            split_pos;
	logic [FA_W-1:0]             free_pos;
	logic                        free_ok;
	logic [OA_W-1:0]             out_addr;

	logic                        free_we;
	logic                        size_we;
	logic [ADDR_W-1:0]           waddr;
	logic                        wfree;
	logic [CNT_W-1:0]            wsize;

	assign cmd_fire = ctrl.ready && cmd_valid;
	assign need     = NEED_W'(item_q.request_size) + NEED_W'(HEADER_UNITS);

	// entry 0 holds the whole pool until it is first written
	assign rd_is0  = (pos_q == '0);
	assign rd_free = (rd_is0 && !free0_wr_q) ? 1'b1 : rd_free_ram;
	assign rd_size = (rd_is0 && !size0_wr_q) ? CNT_W'(POOL_UNITS) : rd_size_ram;
	assign room    = CNT_W'(POOL_UNITS) - pos_q;

	assign rest      = sz_q - need[CNT_W-1:0];
	assign split_ok  = rest >= CNT_W'(HEADER_UNITS);
	assign taken     = split_ok ? need[CNT_W-1:0] : sz_q;
	assign split_pos = pos_q + need[CNT_W-1:0];

	assign free_pos = FA_W'(item_q.free_address) - FA_W'(HEADER_UNITS);
	assign free_ok  = (item_q.free_address >= ffba_pkg::FADDR_W'(HEADER_UNITS))
		&& (free_pos < FA_W'(POOL_UNITS));

	assign out_addr = OA_W'(pos_q) + OA_W'(HEADER_UNITS);

	assign status.cmd_valid = cmd_valid;
	assign status.is_free   = (item_q.action == ffba_pkg::ACT_FREE);
	assign status.pos_end   = pos_q >= CNT_W'(POOL_UNITS);
	assign status.bad       = (rd_size == '0) || (rd_size > room);
	assign status.fit       = hfree_q && (NEED_W'(sz_q) >= need);
	assign status.out_busy  = res_valid_q && !res_ready;

	always_comb begin
		free_we = 1'b0;
		size_we = 1'b0;
		waddr   = pos_q[ADDR_W-1:0];
		wfree   = 1'b0;
		wsize   = taken;
		if (ctrl.wr_head) begin
			free_we = 1'b1;
			size_we = 1'b1;
		end else if (ctrl.wr_split && split_ok) begin
			free_we = 1'b1;
			size_we = 1'b1;
			wfree   = 1'b1;
			wsize   = rest;
			waddr   = split_pos[ADDR_W-1:0];
		end else if (ctrl.wr_free && free_ok) begin
			free_we = 1'b1;
			wfree   = 1'b1;
			waddr   = free_pos[ADDR_W-1:0];
		end
	end

	ffba_ram #(
		.WIDTH(1),
		.DEPTH(POOL_UNITS)
	) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (waddr),
		.wdata (wfree),
		.re    (ctrl.rd && !status.pos_end),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (rd_free_ram)
	);

	ffba_ram #(
		.WIDTH(CNT_W),
		.DEPTH(POOL_UNITS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (waddr),
		.wdata (wsize),
		.re    (ctrl.rd && !status.pos_end),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (rd_size_ram)
	);

	// payload, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_q <= cmd;
		end
		if (ctrl.cap) begin
			sz_q    <= rd_size;
			hfree_q <= rd_free;
		end
		if (cmd_fire) begin
			pos_q <= hint_q;
		end else if (ctrl.adv) begin
			pos_q <= pos_q + sz_q;
		end
		case (ctrl.res_set)
			ffba_pkg::RES_GRANT: begin
				res_grant_q <= 1'b1;
				res_addr_q  <= out_addr[ffba_pkg::BADDR_W-1:0];
			end
			ffba_pkg::RES_ZERO: begin
				res_grant_q <= 1'b0;
				res_addr_q  <= '0;
			end
			default: ;
		endcase
		if (ctrl.emit) begin
			res_q.granted       <= res_grant_q;
			res_q.block_address <= res_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q      <= '0;
			free0_wr_q  <= 1'b0;
			size0_wr_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (free_we && waddr == '0) begin
				free0_wr_q <= 1'b1;
			end
			if (size_we && waddr == '0) begin
				size0_wr_q <= 1'b1;
			end
			if (ctrl.set_hint && pos_q == hint_q) begin
				hint_q <= pos_q + taken;
			end else if (ctrl.wr_free && free_ok && CNT_W'(free_pos) < hint_q) begin
				hint_q <= CNT_W'(free_pos);
			end
			if (ctrl.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/first_fit_block_allocator_top.sv
// First-fit block allocator: top level joining the microcode sequencer and datapath.
// Depends on ffba_pkg, ffba_useq, ffba_datapath (and ffba_ram below it).
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one allocate or free transaction.
//   res channel (res_valid/res_ready/res): exactly one result per command.
//   The block works on one command at a time; cmd_ready is high only while
//   the sequencer waits for work.
// Sequence: a free passes the dispatch, free and output-wait steps before
//   the result is offered. An allocate walks the header chain from the
//   lowest-free hint, one header read from the header RAMs per pass of the
//   walk steps (read, check, fit test, step); a grant writes the header and,
//   if the rest is large enough, a split header; a failure is given when a
//   bad header stops the walk or when the walk runs off the pool end.
// Next command: accepted the cycle after a result is loaded.
// Reset: the pool is one free block spanning all units, the hint is zero;
//   entry 0 reads as that block until first written, so no clearing pass.
// Stall: the result waits in an output register; the next command may be
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register has been taken.
module first_fit_block_allocator_top #(
	parameter int POOL_UNITS   = ffba_pkg::POOL_UNITS_DEF,
	parameter int HEADER_UNITS = ffba_pkg::HEADER_UNITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ffba_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output ffba_pkg::res_t res
);

	ffba_pkg::dp_ctrl_t   dp_ctrl;
	ffba_pkg::dp_status_t dp_status;

	ffba_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (dp_status),
		.ctrl   (dp_ctrl)
	);

	ffba_datapath #(
		.POOL_UNITS   (POOL_UNITS),
		.HEADER_UNITS (HEADER_UNITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dp_ctrl),
		.status    (dp_status),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign cmd_ready = dp_ctrl.ready;

	// a command leaves the idle step at once
	a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("sequencer stayed idle after accepting a command");

	// a result is loaded only into an empty output register
	a_emit_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctrl.emit |-> !res_valid)
		else $error("result loaded over a pending result");

	// results appear only through the emit step
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(dp_ctrl.emit))
		else $error("result valid without an emit step");

	// header RAMs are never written while waiting for a command
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctrl.ready |-> !(dp_ctrl.wr_head || dp_ctrl.wr_split || dp_ctrl.wr_free))
		else $error("header write in idle step");

endmodule
